[sv/multi_channel_pid_controller_defines.svh]
// ---------------------------------------------------------------------------
// multi_channel_pid_controller_defines
// Assertion macros shared by the PID controller RTL.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PID_CONTROLLER_DEFINES_SVH
`define MULTI_CHANNEL_PID_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MCPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MCPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mcpid_pkg.sv]
// ---------------------------------------------------------------------------
// mcpid_pkg
// Widths, register indexes, reset values and the item type of the
// multi-channel PID controller.
// ---------------------------------------------------------------------------
package mcpid_pkg;

  // default channel count
  localparam int CHANNELS_DEF = 8;

  // field widths
  localparam int CH_W    = 3;
  localparam int MEAS_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 16;
  localparam int INTEG_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = INTEG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTEGRAL_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTEGRAL_MAX = 1'd1;

  localparam logic signed [INTEG_W-1:0] INTEG_MIN_RST = 24'sh800000;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX_RST = 24'sh7FFFFF;

  // one input item
  typedef struct packed {
    logic        [CH_W-1:0]    channel;
    logic signed [MEAS_W-1:0]  measurement;
    logic signed [MEAS_W-1:0]  setpoint;
    logic        [GAIN_W-1:0]  gain_p;
    logic        [GAIN_W-1:0]  gain_i;
    logic        [GAIN_W-1:0]  gain_d;
    logic signed [DRIVE_W-1:0] drive_min;
    logic signed [DRIVE_W-1:0] drive_max;
  } mcpid_item_t;

endpackage

[sv/mcpid_ram.sv]
// ---------------------------------------------------------------------------
// mcpid_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mcpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/mcpid_calc.sv]
// ---------------------------------------------------------------------------
// mcpid_calc
// PID datapath for one item: error, derivative on measurement, clamped
// integral update and the clamped weighted sum of the three terms.
// ---------------------------------------------------------------------------
module mcpid_calc (
  input  mcpid_pkg::mcpid_item_t                     item,
  input  logic signed [mcpid_pkg::MEAS_W-1:0]        prev_meas,
  input  logic signed [mcpid_pkg::INTEG_W-1:0]       integ_in,
  input  logic signed [mcpid_pkg::INTEG_W-1:0]       integ_min,
  input  logic signed [mcpid_pkg::INTEG_W-1:0]       integ_max,
  output logic signed [mcpid_pkg::INTEG_W-1:0]       integ_out,
  output logic signed [mcpid_pkg::DRIVE_W-1:0]       drive_value
);
  import mcpid_pkg::*;

  logic signed [MEAS_W:0]      err;
  logic signed [MEAS_W:0]      delta;
  logic signed [INTEG_W:0]     isum;
  logic signed [INTEG_W-1:0]   acc;
  logic signed [2*MEAS_W+1:0]  p_prod;
  logic signed [2*MEAS_W+1:0]  d_prod;
  logic signed [INTEG_W+GAIN_W:0] i_prod;
  logic signed [2*MEAS_W-7:0]  p_term;
  logic signed [2*MEAS_W-7:0]  d_term;
  logic signed [INTEG_W+GAIN_W-8:0] i_term;
  logic signed [2*MEAS_W+2:0]  y;

  // error and derivative on measurement, 17-bit
  assign err   = {item.setpoint[MEAS_W-1], item.setpoint}
               - {item.measurement[MEAS_W-1], item.measurement};
  assign delta = {prev_meas[MEAS_W-1], prev_meas}
               - {item.measurement[MEAS_W-1], item.measurement};

  // integral update with min-first clamp
  assign isum = {integ_in[INTEG_W-1], integ_in}
              + {{(INTEG_W-MEAS_W){err[MEAS_W]}}, err};

  always_comb begin
    if (isum < integ_min) begin
      acc = integ_min;
    end else if (isum > integ_max) begin
      acc = integ_max;
    end else begin
      acc = isum[INTEG_W-1:0];
    end
  end

  assign integ_out = acc;

  // gain products, gains taken as positive signed operands
  assign p_prod = err   * $signed({1'b0, item.gain_p});
  assign d_prod = delta * $signed({1'b0, item.gain_d});
  assign i_prod = acc   * $signed({1'b0, item.gain_i});

  // Q8.8 scaling, floor
  assign p_term = p_prod[2*MEAS_W+1:8];
  assign d_term = d_prod[2*MEAS_W+1:8];
  assign i_term = i_prod[INTEG_W+GAIN_W:8];

  assign y = {{9{p_term[2*MEAS_W-7]}}, p_term}
           + {{9{d_term[2*MEAS_W-7]}}, d_term}
           + {{2{i_term[INTEG_W+GAIN_W-8]}}, i_term};

  // drive clamp, min checked first
  always_comb begin
    if (y < item.drive_min) begin
      drive_value = item.drive_min;
    end else if (y > item.drive_max) begin
      drive_value = item.drive_max;
    end else begin
      drive_value = y[DRIVE_W-1:0];
    end
  end

endmodule

[sv/multi_channel_pid_controller.sv]
// ---------------------------------------------------------------------------
// multi_channel_pid_controller
// Multi-channel PID controller with derivative on measurement.
// ---------------------------------------------------------------------------
// Takes one item per clock, indefinitely, while the output is not stalled;
// each accepted item is held in the stage 1 register and its result moves
// into the output register once no stalled result holds that register. The
// datapath is a single pass: per-channel state (last measurement and
// integral) is read from a small RAM on acceptance, the whole PID sum is
// formed in the next cycle and written back as the result moves into the
// output register. Items on the same channel may follow each
// other in consecutive cycles; the freshly written state is forwarded. Per
// channel valid flags make unwritten state read as zero after reset, so no
// clearing pass is needed. Channel numbers wrap modulo CHANNELS. The
// integral limits must only be written while the block is idle.
// ---------------------------------------------------------------------------
`include "multi_channel_pid_controller_defines.svh"

module multi_channel_pid_controller #(
  parameter int CHANNELS = mcpid_pkg::CHANNELS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input items
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic        [mcpid_pkg::CH_W-1:0]       in_channel,
  input  logic signed [mcpid_pkg::MEAS_W-1:0]     in_measurement,
  input  logic signed [mcpid_pkg::MEAS_W-1:0]     in_setpoint,
  input  logic        [mcpid_pkg::GAIN_W-1:0]     in_gain_p,
  input  logic        [mcpid_pkg::GAIN_W-1:0]     in_gain_i,
  input  logic        [mcpid_pkg::GAIN_W-1:0]     in_gain_d,
  input  logic signed [mcpid_pkg::DRIVE_W-1:0]    in_drive_min,
  input  logic signed [mcpid_pkg::DRIVE_W-1:0]    in_drive_max,
  // result items
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mcpid_pkg::DRIVE_W-1:0]    out_drive_value,
  // configuration
  input  logic                                    cfg_wr_en,
  input  logic        [mcpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mcpid_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mcpid_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = MEAS_W + INTEG_W;

  logic                         in_acc;
  logic                         s1_adv;
  logic [CH_W-1:0]              ch_wrap;
  logic [AW-1:0]                ch_idx;

  logic                         s1_vld_r;
  mcpid_item_t                  s1_item_r;
  logic [AW-1:0]                s1_ch_r;

  logic                         st_fwd_r;
  logic                         st_vld_r;
  logic [SW-1:0]                st_fwd_data_r;
  logic [SW-1:0]                ram_q;
  logic [SW-1:0]                st_word;
  logic [CHANNELS-1:0]          vld_r;

  logic                         wr_en;
  logic [SW-1:0]                wr_data;

  logic signed [INTEG_W-1:0]    imin_r;
  logic signed [INTEG_W-1:0]    imax_r;
  logic signed [INTEG_W-1:0]    integ_nxt;
  logic signed [DRIVE_W-1:0]    drive_nxt;

  logic                         out_vld_r;
  logic signed [DRIVE_W-1:0]    out_drive_r;

  // handshake: stage 1 empties into the output register
  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;

  // channel wrap by repeated subtraction, at most seven steps on 3 bits
  always_comb begin
    ch_wrap = in_channel;
    for (int i = 0; i < 8; i++) begin
      if (int'(ch_wrap) >= CHANNELS) begin
        ch_wrap = ch_wrap - CH_W'(CHANNELS);
      end
    end
  end

  assign ch_idx = AW'(ch_wrap);

  // stage 1 item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{channel:     in_channel,
                     measurement: in_measurement,
                     setpoint:    in_setpoint,
                     gain_p:      in_gain_p,
                     gain_i:      in_gain_i,
                     gain_d:      in_gain_d,
                     drive_min:   in_drive_min,
                     drive_max:   in_drive_max};
      s1_ch_r   <= ch_idx;
    end
  end

  // state write-back as the result leaves stage 1
  assign wr_en   = s1_adv;
  assign wr_data = {integ_nxt, s1_item_r.measurement};

  mcpid_ram #(
    .WIDTH (SW),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_ch_r),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (ch_idx),
    .rdata (ram_q)
  );

  // per-channel written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_ch_r] <= 1'b1;
    end
  end

  // forward a same-edge write to the channel being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_fwd_r <= 1'b0;
      st_vld_r <= 1'b0;
    end else if (in_acc) begin
      st_fwd_r <= wr_en && (s1_ch_r == ch_idx);
      st_vld_r <= vld_r[ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    if (st_fwd_r) begin
      st_word = st_fwd_data_r;
    end else if (st_vld_r) begin
      st_word = ram_q;
    end else begin
      st_word = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imin_r <= INTEG_MIN_RST;
      imax_r <= INTEG_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_INTEGRAL_MIN: imin_r <= $signed(cfg_wdata);
        CFG_IDX_INTEGRAL_MAX: imax_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // datapath
  mcpid_calc u_calc (
    .item        (s1_item_r),
    .prev_meas   ($signed(st_word[MEAS_W-1:0])),
    .integ_in    ($signed(st_word[SW-1:MEAS_W])),
    .integ_min   (imin_r),
    .integ_max   (imax_r),
    .integ_out   (integ_nxt),
    .drive_value (drive_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_drive_value = out_drive_r;

  // checks
  `MCPID_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_vld_r, "accepted item missing from stage 1")
  `MCPID_ASSERT_NOW(a_out_from_s1, $rose(out_vld_r), $past(s1_vld_r), "result without item")
  `MCPID_ASSERT_NEXT(a_fwd_same_ch, in_acc && wr_en && (s1_ch_r == ch_idx), st_fwd_r,
                     "same-channel state not forwarded")
  `MCPID_ASSERT_NEXT(a_wr_sets_vld, wr_en && in_acc && (s1_ch_r == ch_idx), vld_r != '0,
                     "written channel not flagged")

endmodule

[bench/multi_channel_pid_controller_tb.sv]
// ----------------------------------------------------------------------------
// multi_channel_pid_controller_tb
// Self-checking bench for the multi-channel PID controller. A behavioural
// model of the controller keeps its own per-channel state and integral limits
// and predicts the drive value of every accepted item. Results are checked in
// order against those predictions while both sides idle at random, except in
// the last two random phases, where neither side idles. The run has a short
// directed part and then random phases over several integral limit
// settings, including the extremes and reversed limits.
`timescale 1ns / 1ps

module multi_channel_pid_controller_tb;
  import mcpid_pkg::*;

  localparam int PERIOD   = 12;
  localparam int CHANNELS = CHANNELS_DEF;
  localparam int PHASES   = 6;
  localparam int PHASE_ITEMS = 321;

  // Predicts drive values from the accepted items and checks results in order
  class drive_predictor;
    logic signed [MEAS_W-1:0]  last_meas [CHANNELS];
    logic signed [INTEG_W-1:0] integ [CHANNELS];
    logic signed [INTEG_W-1:0] integ_lo;
    logic signed [INTEG_W-1:0] integ_hi;
    logic signed [DRIVE_W-1:0] expected_drive [$];
    int errors;
    int items;
    int results;
    int upper_hits;
    int lower_hits;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        last_meas[i] = '0;
        integ[i]     = '0;
      end
      integ_lo = INTEG_MIN_RST;
      integ_hi = INTEG_MAX_RST;
    endfunction

    function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IDX_INTEGRAL_MIN) integ_lo = val;
      else if (idx == CFG_IDX_INTEGRAL_MAX) integ_hi = val;
    endfunction

    // below lo wins over above hi, so reversed limits behave as the block does
    static function longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function void note_item(mcpid_item_t it);
      int     ch;
      longint meas, sp, err, delta, acc, lo, hi, y;
      longint kp, ki, kd;
      ch    = it.channel % CHANNELS;
      meas  = $signed(it.measurement);
      sp    = $signed(it.setpoint);
      kp    = it.gain_p;
      ki    = it.gain_i;
      kd    = it.gain_d;
      err   = sp - meas;
      delta = longint'($signed(last_meas[ch])) - meas;
      last_meas[ch] = it.measurement;
      // integral update, clamped to the current limits
      lo  = $signed(integ_lo);
      hi  = $signed(integ_hi);
      acc = longint'($signed(integ[ch])) + err;
      if (acc < lo) lower_hits++;
      else if (acc > hi) upper_hits++;
      acc = clip(acc, lo, hi);
      integ[ch] = INTEG_W'(acc);
      // each product floors on the shift
      y = ((err * kp) >>> 8) + ((delta * kd) >>> 8) + ((acc * ki) >>> 8);
      y = clip(y, $signed(it.drive_min), $signed(it.drive_max));
      expected_drive.push_back(DRIVE_W'(y));
      items++;
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] got);
      logic signed [DRIVE_W-1:0] want;
      results++;
      if (expected_drive.size() == 0) begin
        $error("drive_value: none expected, actual %0d", got);
        errors++;
      end else begin
        want = expected_drive.pop_front();
        if (got !== want) begin
          $error("drive_value mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CH_W-1:0] in_channel;
  logic signed [MEAS_W-1:0] in_measurement;
  logic signed [MEAS_W-1:0] in_setpoint;
  logic [GAIN_W-1:0] in_gain_p;
  logic [GAIN_W-1:0] in_gain_i;
  logic [GAIN_W-1:0] in_gain_d;
  logic signed [DRIVE_W-1:0] in_drive_min;
  logic signed [DRIVE_W-1:0] in_drive_max;
  logic out_valid;
  logic out_stall;
  logic signed [DRIVE_W-1:0] out_drive_value;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int src_idle_pct;
  int rcv_idle_pct;
  int limit_settings;

  drive_predictor sb = new();

  multi_channel_pid_controller #(.CHANNELS(CHANNELS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_measurement  (in_measurement),
    .in_setpoint     (in_setpoint),
    .in_gain_p       (in_gain_p),
    .in_gain_i       (in_gain_i),
    .in_gain_d       (in_gain_d),
    .in_drive_min    (in_drive_min),
    .in_drive_max    (in_drive_max),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_value (out_drive_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #(PERIOD / 2) clk = 1'b1;
    #(PERIOD / 2) clk = 1'b0;
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // Result capture
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_drive(out_drive_value);
  end

  function automatic mcpid_item_t pid_item(int ch, int meas, int sp, int kp, int ki, int kd,
                                           int dmin, int dmax);
    mcpid_item_t it;
    it.channel     = CH_W'(ch);
    it.measurement = MEAS_W'(meas);
    it.setpoint    = MEAS_W'(sp);
    it.gain_p      = GAIN_W'(kp);
    it.gain_i      = GAIN_W'(ki);
    it.gain_d      = GAIN_W'(kd);
    it.drive_min   = DRIVE_W'(dmin);
    it.drive_max   = DRIVE_W'(dmax);
    return it;
  endfunction

  // A mix of realistic loops, pushes that drive one channel's integral into
  // its clamp, raw noise and odd output limits
  function automatic mcpid_item_t random_item(int push_pct, bit push_up, int push_ch);
    mcpid_item_t it;
    int sp;
    int lim;
    it.channel     = CH_W'($urandom);
    it.measurement = MEAS_W'($urandom);
    it.setpoint    = MEAS_W'($urandom);
    it.gain_p      = GAIN_W'($urandom);
    it.gain_i      = GAIN_W'($urandom);
    it.gain_d      = GAIN_W'($urandom);
    it.drive_min   = DRIVE_W'($urandom);
    it.drive_max   = DRIVE_W'($urandom);
    if ($urandom_range(0, 99) < push_pct) begin
      it.channel     = CH_W'(push_ch);
      it.measurement = push_up ? 16'sh8000 : 16'sh7FFF;
      it.setpoint    = push_up ? 16'sh7FFF : 16'sh8000;
      it.gain_i      = GAIN_W'($urandom_range(0, 1024));
      it.drive_min   = 16'sh8000;
      it.drive_max   = 16'sh7FFF;
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          // small signal around a setpoint, modest gains
          sp = int'($urandom_range(0, 4000)) - 2000;
          it.setpoint    = MEAS_W'(sp);
          it.measurement = MEAS_W'(sp + int'($urandom_range(0, 200)) - 100);
          it.gain_p      = GAIN_W'($urandom_range(0, 1023));
          it.gain_i      = GAIN_W'($urandom_range(0, 63));
          it.gain_d      = GAIN_W'($urandom_range(0, 1023));
          lim = $urandom_range(0, 1) ? 32767 : 20000;
          it.drive_min   = DRIVE_W'(-lim - (lim == 32767));
          it.drive_max   = DRIVE_W'(lim);
        end
        2: begin
          it.drive_min = DRIVE_W'(-int'($urandom_range(0, 32768)));
          it.drive_max = DRIVE_W'($urandom_range(0, 32767));
        end
        default: begin
          // reversed or equal output limits
          lim = $urandom_range(0, 32767);
          it.drive_min = DRIVE_W'(lim);
          it.drive_max = $urandom_range(0, 1) ? DRIVE_W'(lim) : DRIVE_W'(-lim);
        end
      endcase
    end
    return it;
  endfunction

  // Offers one item and returns at the falling edge after it is taken
  task automatic send_item(input mcpid_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_channel     = it.channel;
    in_measurement = it.measurement;
    in_setpoint    = it.setpoint;
    in_gain_p      = it.gain_p;
    in_gain_i      = it.gain_i;
    in_gain_d      = it.gain_d;
    in_drive_min   = it.drive_min;
    in_drive_max   = it.drive_max;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // Let every expected result come out, then let the pipeline settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(val);
    sb.write_limit(idx, CFG_DATA_W'(val));
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_limits(input int lo, input int hi);
    write_reg(CFG_IDX_INTEGRAL_MIN, lo);
    write_reg(CFG_IDX_INTEGRAL_MAX, hi);
    limit_settings++;
  endtask

  // Stimulus
  initial begin
    int push_pct;
    int lo;
    int hi;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_channel     = '0;
    in_measurement = '0;
    in_setpoint    = '0;
    in_gain_p      = '0;
    in_gain_i      = '0;
    in_gain_d      = '0;
    in_drive_min   = '0;
    in_drive_max   = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    src_idle_pct   = 35;
    rcv_idle_pct   = 53;
    limit_settings = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: field extremes, rounding, output clamps, same-channel bursts
    send_item(pid_item(0, 0, 0, 0, 0, 0, -32768, 32767));
    send_item(pid_item(1, -32768, 32767, 65535, 65535, 65535, -32768, 32767));
    send_item(pid_item(1, 32767, -32768, 65535, 65535, 65535, -32768, 32767));
    send_item(pid_item(2, 32767, 32767, 256, 256, 256, -32768, 32767));
    send_item(pid_item(2, -1, 0, 1, 1, 1, -32768, 32767));
    send_item(pid_item(3, 1, 0, 1, 1, 1, -32768, 32767));
    send_item(pid_item(4, 100, 200, 512, 0, 0, -50, 50));
    send_item(pid_item(4, 300, 200, 512, 0, 0, -50, 50));
    send_item(pid_item(5, 10, 20, 256, 256, 256, 100, -100));
    send_item(pid_item(5, 10, 10, 0, 0, 0, 100, -100));
    send_item(pid_item(6, 5, 7, 300, 300, 300, 1234, 1234));
    send_item(pid_item(7, -32768, -32768, 65535, 0, 65535, 32767, -32768));
    send_item(pid_item(7, 1000, -1000, 256, 256, 256, -32768, 32767));
    send_item(pid_item(7, -1000, 1000, 256, 256, 256, -32768, 32767));
    drain();

    // integral running into a tight clamp both ways
    set_limits(-100000, 100000);
    repeat (3) send_item(pid_item(0, -32768, 32767, 0, 256, 0, -32768, 32767));
    repeat (4) send_item(pid_item(0, 32767, -32768, 0, 256, 0, -32768, 32767));
    drain();

    // reversed integral limits
    set_limits(1000, -1000);
    send_item(pid_item(1, 0, 500, 0, 256, 0, -32768, 32767));
    send_item(pid_item(1, 0, -500, 0, 256, 0, -32768, 32767));
    drain();

    // random phases, one limit setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo = $signed(INTEG_MIN_RST); hi = $signed(INTEG_MAX_RST); push_pct = 55; end
        1: begin lo = -20000; hi = 20000; push_pct = 20; end
        2: begin lo = 5000; hi = -5000; push_pct = 10; end
        3: begin lo = 8388607; hi = 8388607; push_pct = 10; end
        4: begin lo = -8388608; hi = -8388608; push_pct = 10; end
        default: begin lo = -300000; hi = 1000000; push_pct = 30; end
      endcase
      src_idle_pct = (p < 2) ? 35 : (p < 4) ? 53 : 0;
      rcv_idle_pct = (p < 2) ? 53 : (p < 4) ? 35 : 0;
      set_limits(lo, hi);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(push_pct, (p % 2) == 0, p % CHANNELS));
      end
      drain();
    end

    $display("Ran %0d items and checked %0d results over %0d integral limit settings.",
             sb.items, sb.results, limit_settings);
    $display("Integral clamped %0d times at the upper limit, %0d at the lower.",
             sb.upper_hits, sb.lower_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[multi_channel_pid_controller] OK");
    end else begin
      $display("[multi_channel_pid_controller] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(200000 * PERIOD);
    $display("[multi_channel_pid_controller] ERROR");
    $finish;
  end

endmodule

[multi_channel_pid_controller.f]
+incdir+sv
sv/mcpid_pkg.sv
sv/mcpid_ram.sv
sv/mcpid_calc.sv
sv/multi_channel_pid_controller.sv
bench/multi_channel_pid_controller_tb.sv
